// File: rtl/tpt_pkg.sv
// Package for the tag presence table: shared types, field widths and codes.
// Used by tpt_ctrl, tpt_dp and tag_presence_table_core; depends on nothing.
`default_nettype none

package tpt_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ID_BYTES   = 10;
  localparam int unsigned ID_W       = 8 * ID_BYTES;
  localparam int unsigned ID_LOW_W   = 64;
  localparam int unsigned ID_HIGH_W  = ID_W - ID_LOW_W;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned AGE_W      = 4;
  localparam int unsigned MISS_W     = 5;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned CNT_OUT_W  = 3;

  // Saturation points
  localparam logic [AGE_W-1:0]  AGE_MAX  = '1;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  // Configuration port
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 4;
  localparam int unsigned MISS_LIMIT_W   = 4;
  localparam int unsigned AGE_SLACK_W    = 3;
  localparam logic [MISS_LIMIT_W-1:0] MISS_LIMIT_RST = 4'd2;
  localparam logic [AGE_SLACK_W-1:0]  AGE_SLACK_RST  = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_LIMIT = 1'b0,
    CFG_AGE_SLACK  = 1'b1
  } tpt_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_COMPACT,
    ST_UPDATE,
    ST_QUERY,
    ST_DONE
  } tpt_state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_item;
    logic age;
    logic compact;
    logic update;
    logic query;
    logic load_out;
  } tpt_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic expire_any;
  } tpt_sts_t;

  // Byte mask over the ID: bytes below the size take part in a compare
  function automatic logic [ID_W-1:0] id_byte_mask(logic [SIZE_W-1:0] size);
    logic [ID_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < ID_BYTES; b++) begin
      mask[8*b +: 8] = {8{SIZE_W'(b) < size}};
    end
    return mask;
  endfunction

endpackage : tpt_pkg

`default_nettype wire

// File: rtl/tpt_ctrl.sv
// Sequencer for the tag presence table: walks each beat through its steps.
// Depends on tpt_pkg; drives tpt_dp through tpt_cmd_t.
`default_nettype none

module tpt_ctrl
  import tpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     func_i,
  input  wire logic     out_stall_i,
  input  wire tpt_sts_t sts_i,
  output tpt_cmd_t      cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);

  tpt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = func_i ? ST_QUERY : ST_AGE;
        end
      end
      ST_AGE:     state_d = ST_COMPACT;
      ST_COMPACT: begin
        if (!sts_i.expire_any) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE:  state_d = ST_DONE;
      ST_QUERY:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_AGE:     cmd_o.age     = 1'b1;
      ST_COMPACT: cmd_o.compact = sts_i.expire_any;
      ST_UPDATE:  cmd_o.update  = 1'b1;
      ST_QUERY:   cmd_o.query   = 1'b1;
      ST_DONE:    cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : tpt_ctrl

`default_nettype wire

// File: rtl/tpt_dp.sv
// Datapath of the tag presence table: entry store, ageing, compaction, match.
// Depends on tpt_pkg; steered by tpt_ctrl through tpt_cmd_t.
`default_nettype none

module tpt_dp
  import tpt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tpt_cmd_t              cmd_i,
  output tpt_sts_t                   sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  card_answered_i,
  input  wire logic                  serial_ok_i,
  input  wire logic [SIZE_W-1:0]     id_size_i,
  input  wire logic [ID_LOW_W-1:0]   id_low_i,
  input  wire logic [ID_HIGH_W-1:0]  id_high_i,
  output logic                       present_o,
  output logic                       known_o,
  output logic [SLOT_W-1:0]          matched_slot_o,
  output logic [CNT_OUT_W-1:0]       entry_count_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned LimW = CntW + 4;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  // Configuration
  logic [MISS_LIMIT_W-1:0] miss_limit_q;
  logic [AGE_SLACK_W-1:0]  age_slack_q;

  // Held beat
  logic              answered_q;
  logic              serial_ok_q;
  logic [SIZE_W-1:0] item_size_q;
  logic [ID_W-1:0]   item_id_q;

  // Entry store
  logic [ID_W-1:0]   id_q    [MAX_ENTRIES];
  logic [ID_W-1:0]   id_d    [MAX_ENTRIES];
  logic [SIZE_W-1:0] size_q  [MAX_ENTRIES];
  logic [SIZE_W-1:0] size_d  [MAX_ENTRIES];
  logic [AGE_W-1:0]  age_q   [MAX_ENTRIES];
  logic [AGE_W-1:0]  age_d   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] exp_q, exp_d;

  // Control state
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic              found_q, found_d;
  logic              present_q, present_d;
  logic              pres_before_q, pres_before_d;

  // Per-beat results
  logic              known_q, known_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // Output register
  logic                 out_present_q;
  logic                 out_known_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  // Match and ageing terms
  logic [ID_W-1:0]        cmp_mask;
  logic [MAX_ENTRIES-1:0] hit;
  logic                   hit_any;
  logic [IdxW-1:0]        hit_idx;
  logic [AGE_W-1:0]       age_inc [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] expire;
  logic [MAX_ENTRIES-1:0] shift_sel;
  logic [LimW-1:0]        age_limit;
  logic [MISS_W-1:0]      miss_inc;
  logic                   poll_ok;
  logic                   found_next;

  assign cmp_mask  = id_byte_mask(item_size_q);
  assign age_limit = LimW'(cnt_q) + LimW'(age_slack_q);
  assign miss_inc  = (miss_q == MISS_MAX) ? miss_q : miss_q + 1'b1;
  assign poll_ok   = answered_q && serial_ok_q;
  assign found_next = poll_ok ? 1'b1 : found_q;

  // One compare lane per entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = (CntW'(i) < cnt_q) && (size_q[i] == item_size_q)
               && (((id_q[i] ^ item_id_q) & cmp_mask) == '0);
      age_inc[i] = (age_q[i] == AGE_MAX) ? age_q[i] : age_q[i] + 1'b1;
      expire[i]  = (CntW'(i) < cnt_q) && (LimW'(age_inc[i]) > age_limit);
    end
  end

  // Lowest matching slot wins
  always_comb begin
    hit_any = |hit;
    hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  // Entries at or above the lowest expired one move down a slot
  always_comb begin
    shift_sel[0] = exp_q[0];
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      shift_sel[i] = shift_sel[i-1] | exp_q[i];
    end
  end

  assign sts_o.expire_any = |exp_q;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      id_d[i]   = id_q[i];
      size_d[i] = size_q[i];
      age_d[i]  = age_q[i];
    end
    exp_d         = exp_q;
    cnt_d         = cnt_q;
    miss_d        = miss_q;
    found_d       = found_q;
    present_d     = present_q;
    pres_before_d = pres_before_q;
    known_d       = known_q;
    slot_d        = slot_q;

    if (cmd_i.age) begin
      pres_before_d = present_q;
      miss_d        = miss_inc;
      if (miss_inc > MISS_W'(miss_limit_q)) begin
        found_d = 1'b0;
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_d[i] = age_inc[i];
      end
      exp_d = expire;
    end

    if (cmd_i.compact) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (shift_sel[i]) begin
          id_d[i]   = id_q[i+1];
          size_d[i] = size_q[i+1];
          age_d[i]  = age_q[i+1];
          exp_d[i]  = exp_q[i+1];
        end
      end
      // The top slot never stays flagged: it has moved down or was itself the expired one
      exp_d[MAX_ENTRIES-1] = 1'b0;
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.update) begin
      known_d = 1'b0;
      slot_d  = '0;
      if (poll_ok) begin
        if (hit_any) begin
          age_d[hit_idx] = '0;
        end else if (cnt_q < MaxCnt) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CntW'(i) == cnt_q) begin
              id_d[i]   = item_id_q;
              size_d[i] = item_size_q;
              age_d[i]  = '0;
            end
          end
          cnt_d = cnt_q + 1'b1;
        end
        miss_d  = '0;
        found_d = 1'b1;
      end
      // A failed serial read leaves presence untouched
      if (!(answered_q && !serial_ok_q)) begin
        present_d = found_next;
        if (!found_next && pres_before_q) begin
          cnt_d = '0;
        end
      end
    end

    if (cmd_i.query) begin
      known_d = hit_any;
      slot_d  = hit_any ? SLOT_W'(hit_idx) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_limit_q  <= MISS_LIMIT_RST;
      age_slack_q   <= AGE_SLACK_RST;
      exp_q         <= '0;
      cnt_q         <= '0;
      miss_q        <= '0;
      found_q       <= 1'b0;
      present_q     <= 1'b0;
      pres_before_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MISS_LIMIT: miss_limit_q <= cfg_data_i[MISS_LIMIT_W-1:0];
          CFG_AGE_SLACK:  age_slack_q  <= cfg_data_i[AGE_SLACK_W-1:0];
          default: ;
        endcase
      end
      exp_q         <= exp_d;
      cnt_q         <= cnt_d;
      miss_q        <= miss_d;
      found_q       <= found_d;
      present_q     <= present_d;
      pres_before_q <= pres_before_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      id_q[i]   <= id_d[i];
      size_q[i] <= size_d[i];
      age_q[i]  <= age_d[i];
    end
    known_q <= known_d;
    slot_q  <= slot_d;
    if (cmd_i.load_item) begin
      answered_q  <= card_answered_i;
      serial_ok_q <= serial_ok_i;
      item_size_q <= id_size_i;
      item_id_q   <= {id_high_i, id_low_i};
    end
    if (cmd_i.load_out) begin
      out_present_q <= present_q;
      out_known_q   <= known_q;
      out_slot_q    <= slot_q;
      out_cnt_q     <= CNT_OUT_W'(cnt_q);
    end
  end

  assign present_o      = out_present_q;
  assign known_o        = out_known_q;
  assign matched_slot_o = out_slot_q;
  assign entry_count_o  = out_cnt_q;

endmodule : tpt_dp

`default_nettype wire

// File: rtl/tag_presence_table_core.sv
// Top level of the tag presence table: sequencer plus datapath.
// Depends on tpt_pkg, tpt_ctrl and tpt_dp.
//
// Usage
//   Input channel: in_valid_i / in_stall_o with one beat per poll result
//   (func_i = 0) or query (func_i = 1). A beat is taken when in_valid_i is
//   high and in_stall_o is low. Output channel: out_valid_o / out_stall_i,
//   one result beat per input beat, in order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 = miss limit, 1 = age slack); write only while the block is idle.
// Sequence
//   One beat is worked on at a time. A poll runs an ageing step, then one
//   compaction step per expired entry plus one closing check, an update
//   step, a step that loads the output register once it is free, and a
//   return to idle where the next beat is taken. A query runs a match step,
//   the output load and the return to idle. Besides output back-pressure,
//   the number of expired entries sets how long a poll lasts.
// Reset and back-pressure
//   Reset empties the table, clears presence and the miss counter and loads
//   the default configuration. The output register decouples the sides: a
//   new beat is taken while a result waits; a finished result then holds in
//   the sequencer until the output register is free.
`default_nettype none

module tag_presence_table_core
  import tpt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input beat
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic                  card_answered_i,
  input  wire logic                  serial_ok_i,
  input  wire logic [SIZE_W-1:0]     id_size_i,
  input  wire logic [ID_LOW_W-1:0]   id_low_i,
  input  wire logic [ID_HIGH_W-1:0]  id_high_i,
  // Result beat
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       present_o,
  output logic                       known_o,
  output logic [SLOT_W-1:0]          matched_slot_o,
  output logic [CNT_OUT_W-1:0]       entry_count_o
);

  tpt_cmd_t cmd;
  tpt_sts_t sts;

  // Sequencer: decides which step runs and owns the result valid
  tpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Datapath: entry store with per-entry compare lanes and a shift-down
  // compaction network, plus the presence counters and the output register
  tpt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .card_answered_i (card_answered_i),
    .serial_ok_i     (serial_ok_i),
    .id_size_i       (id_size_i),
    .id_low_i        (id_low_i),
    .id_high_i       (id_high_i),
    .present_o       (present_o),
    .known_o         (known_o),
    .matched_slot_o  (matched_slot_o),
    .entry_count_o   (entry_count_o)
  );

  // Only one step runs in any cycle
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.age, cmd.compact, cmd.update, cmd.query,
              cmd.load_out}))
    else $error("more than one datapath step in a cycle");

  // Ageing follows straight on from taking a beat
  a_age_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.age |-> $past(cmd.load_item))
    else $error("ageing step without a freshly taken beat");

  // Compaction only runs while an expired entry remains
  a_compact_needs_expiry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.compact |-> sts.expire_any)
    else $error("compaction step with nothing expired");

  // A result is loaded right after its work, or after waiting on a full output
  a_load_out_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> ($past(cmd.update) || $past(cmd.query)
                      || ($past(out_valid_o) && $past(out_stall_i))))
    else $error("result loaded out of sequence");

endmodule : tag_presence_table_core

`default_nettype wire

// File: dv/tb_tag_presence_table_core.sv
// Self-checking testbench for tag_presence_table_core: directed and random beats.
// Needs tpt_pkg and the RTL of tag_presence_table_core; an internal predictor supplies results.

module tb_tag_presence_table_core
  import tpt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH   = 5;
  localparam int unsigned POOL_DEPTH    = 8;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic {
    FN_POLL  = 1'b0,
    FN_QUERY = 1'b1
  } tag_func_e;

  // One input beat
  typedef struct packed {
    tag_func_e          func;
    logic               answered;
    logic               serial_ok;
    logic [SIZE_W-1:0]  size;
    logic [ID_W-1:0]    id;
  } tag_beat_t;

  // One result beat
  typedef struct packed {
    logic                 present;
    logic                 known;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_OUT_W-1:0] count;
  } tag_status_t;

  // DUT connections, all inputs known from time zero
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic                  func_i          = 1'b0;
  logic                  card_answered_i = 1'b0;
  logic                  serial_ok_i     = 1'b0;
  logic [SIZE_W-1:0]     id_size_i       = '0;
  logic [ID_LOW_W-1:0]   id_low_i        = '0;
  logic [ID_HIGH_W-1:0]  id_high_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic                  present_o;
  logic                  known_o;
  logic [SLOT_W-1:0]     matched_slot_o;
  logic [CNT_OUT_W-1:0]  entry_count_o;

  // Predicted table contents and flags
  logic [ID_W-1:0]         tag_ids   [TABLE_DEPTH];
  logic [SIZE_W-1:0]       tag_sizes [TABLE_DEPTH];
  logic [AGE_W-1:0]        tag_ages  [TABLE_DEPTH];
  int unsigned             tag_count;
  logic [MISS_W-1:0]       missed_polls;
  logic                    card_seen;
  logic                    presence;
  logic [MISS_LIMIT_W-1:0] miss_limit_q;
  logic [AGE_SLACK_W-1:0]  age_slack_q;

  // Results still owed by the block, oldest first
  tag_status_t pending_status[$];

  // Card pool used to build repeat visits
  logic [ID_W-1:0]   pool_id   [POOL_DEPTH];
  logic [SIZE_W-1:0] pool_size [POOL_DEPTH];

  int unsigned sender_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  tag_presence_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .card_answered_i(card_answered_i),
    .serial_ok_i    (serial_ok_i),
    .id_size_i      (id_size_i),
    .id_low_i       (id_low_i),
    .id_high_i      (id_high_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .present_o      (present_o),
    .known_o        (known_o),
    .matched_slot_o (matched_slot_o),
    .entry_count_o  (entry_count_o)
  );

  always #10 clk_i = ~clk_i;

  // Count cycles; the watchdog below ends a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_tag_presence_table_core NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Only the first min(size, 10) bytes of an ID take part in a compare
  function automatic logic [ID_W-1:0] compared_bytes(logic [SIZE_W-1:0] size);
    logic [ID_W-1:0] mask;
    int unsigned     nbytes;
    mask   = '0;
    nbytes = (size > ID_BYTES) ? ID_BYTES : size;
    for (int b = 0; b < nbytes; b++) begin
      mask[8*b +: 8] = 8'hFF;
    end
    return mask;
  endfunction

  // Slot holding this ID, or -1; only occupied slots are looked at
  function automatic int find_tag(logic [SIZE_W-1:0] size, logic [ID_W-1:0] id);
    for (int i = 0; i < tag_count; i++) begin
      if (tag_sizes[i] == size && ((tag_ids[i] ^ id) & compared_bytes(size)) == '0) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void reset_table();
    tag_count    = 0;
    missed_polls = '0;
    card_seen    = 1'b0;
    presence     = 1'b0;
    miss_limit_q = MISS_LIMIT_RST;
    age_slack_q  = AGE_SLACK_RST;
  endfunction

  // Advance the predicted table by one beat and return the status it reports
  function automatic tag_status_t predict_status(tag_beat_t beat);
    tag_status_t      st;
    int               hit;
    int unsigned      kept;
    int unsigned      age_cap;
    logic [AGE_W-1:0] age;
    logic             was_present;
    logic             read_failed;
    st = '0;
    if (beat.func == FN_QUERY) begin
      hit = find_tag(beat.size, beat.id);
      if (hit >= 0) begin
        st.known = 1'b1;
        st.slot  = SLOT_W'(hit);
      end
    end else begin
      was_present = presence;
      read_failed = 1'b0;
      if (missed_polls != MISS_MAX) missed_polls++;
      if (missed_polls > miss_limit_q) card_seen = 1'b0;
      // Age every entry, drop the stale ones and close up the gaps in order
      age_cap = tag_count + age_slack_q;
      kept    = 0;
      for (int i = 0; i < tag_count; i++) begin
        age = tag_ages[i];
        if (age != AGE_MAX) age++;
        if (age <= age_cap) begin
          tag_ids[kept]   = tag_ids[i];
          tag_sizes[kept] = tag_sizes[i];
          tag_ages[kept]  = age;
          kept++;
        end
      end
      tag_count = kept;
      if (beat.answered) begin
        if (!beat.serial_ok) begin
          read_failed = 1'b1;
        end else begin
          hit = find_tag(beat.size, beat.id);
          if (hit >= 0) begin
            tag_ages[hit] = '0;
          end else if (tag_count < TABLE_DEPTH) begin
            tag_ids[tag_count]   = beat.id;
            tag_sizes[tag_count] = beat.size;
            tag_ages[tag_count]  = '0;
            tag_count++;
          end
          missed_polls = '0;
          card_seen    = 1'b1;
        end
      end
      // A failed serial read leaves presence as it is and does not clear the table
      if (!read_failed) begin
        presence = card_seen;
        if (!presence && was_present) tag_count = 0;
      end
    end
    st.present = presence;
    st.count   = CNT_OUT_W'(tag_count);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random, check every accepted beat
  // ---------------------------------------------------------------------------

  task automatic check_status(input tag_status_t got);
    tag_status_t want;
    if (pending_status.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: unexpected result beat: present=%0b known=%0b slot=%0d count=%0d",
                 $realtime, got.present, got.known, got.slot, got.count);
      end
    end else begin
      want = pending_status.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: mismatch exp/act present %0b/%0b known %0b/%0b",
                   $realtime, want.present, got.present, want.known, got.known);
          $display("    slot %0d/%0d count %0d/%0d",
                   want.slot, got.slot, want.count, got.count);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_status('{present: present_o, known: known_o, slot: matched_slot_o,
                     count: entry_count_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one beat, idling first at random; valid stays up between back-to-back beats
  task automatic send_beat(input tag_beat_t beat);
    if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid_i      <= 1'b1;
    func_i          <= beat.func;
    card_answered_i <= beat.answered;
    serial_ok_i     <= beat.serial_ok;
    id_size_i       <= beat.size;
    id_low_i        <= beat.id[ID_LOW_W-1:0];
    id_high_i       <= beat.id[ID_W-1:ID_LOW_W];
    do @(posedge clk_i); while (in_stall_o);
    pending_status.push_back(predict_status(beat));
  endtask

  // Hold the input idle until every owed result is out and the block has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One write beat, then cfg_we_i drops again so that writes never share an edge
  task automatic write_reg(input tpt_cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MISS_LIMIT: miss_limit_q = value[MISS_LIMIT_W-1:0];
      CFG_AGE_SLACK:  age_slack_q  = value[AGE_SLACK_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [ID_W-1:0] random_id();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[ID_W-1:0];
  endfunction

  function automatic tag_beat_t make_beat(tag_func_e func, logic answered, logic serial_ok,
                                          logic [SIZE_W-1:0] size, logic [ID_W-1:0] id);
    tag_beat_t beat;
    beat.func      = func;
    beat.answered  = answered;
    beat.serial_ok = serial_ok;
    beat.size      = size;
    beat.id        = id;
    return beat;
  endfunction

  // A pool card with fresh garbage in the bytes that do not take part in a compare
  function automatic tag_beat_t pool_beat(tag_func_e func, int unsigned slot);
    logic [ID_W-1:0] keep;
    keep = compared_bytes(pool_size[slot]);
    return make_beat(func, 1'b1, 1'b1, pool_size[slot],
                     (pool_id[slot] & keep) | (random_id() & ~keep));
  endfunction

  function automatic tag_beat_t empty_poll();
    return make_beat(FN_POLL, 1'b0, 1'($urandom_range(1)), 4'($urandom_range(15)), random_id());
  endfunction

  function automatic void refill_pool();
    logic [SIZE_W-1:0] common_sizes [3];
    common_sizes = '{4'd4, 4'd7, 4'd10};
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_id[i]   = random_id();
      pool_size[i] = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(15))
                                               : common_sizes[$urandom_range(2)];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Compare rules: full-width IDs, empty IDs, oversized sizes, ignored bytes, failed reads
  task automatic test_match_rules();
    logic [ID_W-1:0] card_c;
    logic [ID_W-1:0] flipped;
    card_c  = random_id();
    flipped = '1;
    flipped[ID_W-1 -: 8] = 8'h7F;
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd10, '1));          // query on an empty table
    send_beat(make_beat(FN_POLL, 1'b0, 1'b1, 4'd3, '0));            // no card
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd10, '1));           // card A, all ones
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd0, '0));            // card B, no ID bytes
    send_beat(make_beat(FN_QUERY, 1'b1, 1'b1, 4'd10, '1));          // A is known
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd0, random_id()));  // B matches any empty ID
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd15, card_c));       // oversized size
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd15, card_c));      // same size and bytes
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd10, card_c));      // size differs: no match
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd10, flipped));     // last byte differs
    send_beat(make_beat(FN_POLL, 1'b1, 1'b0, 4'd10, '1));           // failed serial read
  endtask

  // Fill the table, overflow it, then let presence fall and clear everything
  task automatic test_fill_and_clear();
    logic [ID_W-1:0] extra;
    extra = random_id();
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd4, random_id()));
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd7, random_id()));
    send_beat(make_beat(FN_POLL, 1'b1, 1'b1, 4'd10, extra));        // table full: dropped
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd10, extra));
    repeat (4) send_beat(empty_poll());                             // presence falls, table clears
    send_beat(make_beat(FN_QUERY, 1'b0, 1'b0, 4'd10, '1));
  endtask

  // Mostly repeat visits from a small pool, so entries refresh, expire and overflow;
  // the rest is absent cards, failed reads, strangers and queries
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input logic [MISS_LIMIT_W-1:0] limit,
                                     input logic [AGE_SLACK_W-1:0] slack,
                                     input int unsigned n_beats);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    tag_beat_t   beat;
    logic [ID_W-1:0] id;
    int unsigned nbytes;
    int unsigned b;
    wait_drained();
    write_reg(CFG_MISS_LIMIT, CFG_DATA_W'(limit));
    write_reg(CFG_AGE_SLACK, CFG_DATA_W'(slack));
    sender_gap_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    refill_pool();
    sent = 0;
    while (sent < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        // A long absence: drop presence, sometimes saturate the miss counter
        run = $urandom_range(34, limit + 1);
        repeat (run) send_beat(empty_poll());
        sent += run;
      end else begin
        if (pick < 55) begin
          beat = pool_beat(FN_POLL, $urandom_range(POOL_DEPTH - 1));
        end else if (pick < 65) begin
          beat = empty_poll();
        end else if (pick < 70) begin
          beat = make_beat(FN_POLL, 1'b1, 1'b0, 4'($urandom_range(15)), random_id());
        end else if (pick < 73) begin
          beat = make_beat(FN_POLL, 1'b1, 1'b1, 4'($urandom_range(15)), random_id());
        end else if (pick < 92) begin
          beat = pool_beat(FN_QUERY, $urandom_range(POOL_DEPTH - 1));
          beat.answered  = 1'($urandom_range(1));
          beat.serial_ok = 1'($urandom_range(1));
        end else if (pick < 97) begin
          // Near miss: one compared byte differs
          beat   = pool_beat(FN_QUERY, $urandom_range(POOL_DEPTH - 1));
          nbytes = (beat.size > ID_BYTES) ? ID_BYTES : beat.size;
          if (nbytes != 0) begin
            id = beat.id;
            b  = $urandom_range(nbytes - 1);
            id[8*b +: 8] = id[8*b +: 8] ^ 8'($urandom_range(255, 1));
            beat.id = id;
          end
        end else begin
          beat = make_beat(FN_QUERY, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           4'($urandom_range(15)), random_id());
        end
        send_beat(beat);
        sent++;
      end
    end
  endtask

  initial begin
    reset_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_gap_pct = 10;
    recv_stall_pct = 76;
    test_match_rules();
    test_fill_and_clear();

    test_random_traffic(10, 76, 4'($urandom_range(15)), 3'($urandom_range(7)), 640);
    test_random_traffic(76, 10, '0, '0, 640);
    test_random_traffic(0, 0, '1, '1, 640);

    wait_drained();
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("tb_tag_presence_table_core OK");
    end else begin
      $display("tb_tag_presence_table_core NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tpt_pkg.sv
rtl/tpt_ctrl.sv
rtl/tpt_dp.sv
rtl/tag_presence_table_core.sv
dv/tb_tag_presence_table_core.sv
